// ===== sv/bpa_pkg.sv =====
// Shared types, constants and codes of the bitmap page allocator.
package bpa_pkg;

    localparam int POOL_PAGES = 2048;
    localparam int MAX_RUN    = 64;
    localparam int WORD_W     = 32;
    localparam int WORDS      = POOL_PAGES / WORD_W;
    localparam int WADDR_W    = $clog2(WORDS);
    localparam int IDX_W      = $clog2(POOL_PAGES);
    localparam int LIMIT_W    = IDX_W + 1;
    localparam int CHUNK_W    = 8;
    localparam int CHUNKS     = WORD_W / CHUNK_W;
    localparam int CSEL_W     = $clog2(CHUNKS);
    localparam int BSEL_W     = $clog2(CHUNK_W);
    localparam int PAGE_W     = 20;
    localparam int CNT_W      = 7;
    localparam int POOL_W     = 12;
    localparam int ST_W       = 2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_VIRT = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_PHYS = 2'd2;

    localparam logic [1:0] REG_POOL_PAGES = 2'd0;
    localparam logic [1:0] REG_VIRT_BASE  = 2'd1;
    localparam logic [1:0] REG_PHYS_BASE  = 2'd2;

    typedef struct packed {
        logic              bad;
        logic [CNT_W-1:0]  count;
    } req_t;

    typedef struct packed {
        logic              valid;
        req_t              req;
    } queue_out_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] limit;
        logic [PAGE_W-1:0]  virt_base;
        logic [PAGE_W-1:0]  phys_base;
    } cfg_t;

endpackage

// ===== sv/bitmap_page_allocator_core.sv =====
// Top level of the bitmap page allocator: intake queue, engine and registers.
//
// Channel   Direction  Carries
// s_axis    in         tdata[6:0] page_count
// m_axis    out        tdata virt_page, phys_page; tuser status; tlast last
// APB       in/out     pool_pages at 0x0, virt_base_page at 0x4, phys_base_page at 0x8
//
// The virtual search reads one 32-bit bitmap word at a time and checks eight bits a cycle.
// Marking the run reads and then writes back each touched word. The physical search loads
// each physical bitmap word, checks it byte by byte for free pages and writes it back; a
// page is taken only when the result register is free.
// Reset clears both bitmaps at once through per-word valid flags.
// Two requests may wait in the intake queue while the engine stalls on m_axis_tready.
module bitmap_page_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [6:0] page_count
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [19:0] virt_page, [39:20] phys_page
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bpa_pkg::*;

    cfg_t               cfg;
    queue_out_t         q_out;
    logic               pop;
    logic [PAGE_W-1:0]  out_virt, out_phys;
    logic [ST_W-1:0]    out_status;

    bpa_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bpa_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_count (s_axis_tdata[CNT_W-1:0]),
        .pop      (pop),
        .q_out    (q_out)
    );

    bpa_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .q_in       (q_out),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_virt   (out_virt),
        .out_phys   (out_phys),
        .out_status (out_status),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {out_phys, out_virt};
    assign m_axis_tuser = out_status;

    a_fail_ends_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_status != ST_OK) |-> m_axis_tlast)
        else $error("Failure result does not end its request.");

    a_fail_zero_pages: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && out_status != ST_OK) |-> (out_virt == '0 && out_phys == '0))
        else $error("Failure result carries page numbers.");

    a_pop_only_when_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_out.valid)
        else $error("Engine took a request from an empty queue.");

endmodule

// ===== sv/bpa_regs.sv =====
// Configuration registers of the page allocator behind an APB-style port.
module bpa_regs (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output bpa_pkg::cfg_t        cfg
);
    import bpa_pkg::*;

    logic [POOL_W-1:0]  pool_pages_reg;
    logic [PAGE_W-1:0]  virt_base_reg;
    logic [PAGE_W-1:0]  phys_base_reg;
    logic [POOL_W-1:0]  pool_clamped;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_pages_reg <= POOL_W'(POOL_PAGES);
            virt_base_reg  <= PAGE_W'(786688);
            phys_base_reg  <= PAGE_W'(512);
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_POOL_PAGES: pool_pages_reg <= pwdata[POOL_W-1:0];
                REG_VIRT_BASE:  virt_base_reg  <= pwdata[PAGE_W-1:0];
                REG_PHYS_BASE:  phys_base_reg  <= pwdata[PAGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_POOL_PAGES: prdata = 32'(pool_pages_reg);
            REG_VIRT_BASE:  prdata = 32'(virt_base_reg);
            REG_PHYS_BASE:  prdata = 32'(phys_base_reg);
            default:        prdata = '0;
        endcase
    end

    assign pool_clamped = (pool_pages_reg > POOL_W'(POOL_PAGES)) ? POOL_W'(POOL_PAGES)
                                                                 : pool_pages_reg;
    assign cfg.limit     = LIMIT_W'(pool_clamped) & ~LIMIT_W'(CHUNK_W - 1);
    assign cfg.virt_base = virt_base_reg;
    assign cfg.phys_base = phys_base_reg;

endmodule

// ===== sv/bpa_front.sv =====
// Request intake: checks the page count and queues requests for the engine.
module bpa_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [bpa_pkg::CNT_W-1:0] in_count,
    input  logic                     pop,
    output bpa_pkg::queue_out_t      q_out
);
    import bpa_pkg::*;

    req_t        entry_reg [2];
    logic        wptr_reg;
    logic        rptr_reg;
    logic [1:0]  fill_reg;
    logic        push;
    logic        do_pop;
    req_t        new_req;

    assign in_ready = (fill_reg != 2'd2);
    assign push     = in_valid & in_ready;
    assign do_pop   = pop & (fill_reg != 2'd0);

    assign new_req.count = in_count;
    assign new_req.bad   = (in_count == '0) || (in_count > CNT_W'(MAX_RUN));

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= new_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            if (push) begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_pop) begin
                rptr_reg <= ~rptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(do_pop);
        end
    end

    assign q_out.valid = (fill_reg != 2'd0);
    assign q_out.req   = entry_reg[rptr_reg];

endmodule

// ===== sv/bpa_engine.sv =====
// Allocation engine: bitmap memories, run search, marking and result register.
module bpa_engine (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bpa_pkg::cfg_t              cfg,
    input  bpa_pkg::queue_out_t        q_in,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [bpa_pkg::PAGE_W-1:0] out_virt,
    output logic [bpa_pkg::PAGE_W-1:0] out_phys,
    output logic [bpa_pkg::ST_W-1:0]   out_status,
    output logic                       out_last
);
    import bpa_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_VSCAN = 4'd1;
    localparam logic [3:0] S_VMRD  = 4'd2;
    localparam logic [3:0] S_VMWR  = 4'd3;
    localparam logic [3:0] S_PLOAD = 4'd4;
    localparam logic [3:0] S_PSCAN = 4'd5;
    localparam logic [3:0] S_PWB   = 4'd6;
    localparam logic [3:0] S_FAIL  = 4'd7;

    localparam logic [1:0] WB_DONE = 2'd0;
    localparam logic [1:0] WB_FAIL = 2'd1;
    localparam logic [1:0] WB_NEXT = 2'd2;

    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);
    localparam logic [CSEL_W-1:0]  LAST_CHUNK = CSEL_W'(CHUNKS - 1);

    logic [WORD_W-1:0]  vmem [WORDS];
    logic [WORD_W-1:0]  pmem [WORDS];
    logic [WORDS-1:0]   vvalid_reg;
    logic [WORDS-1:0]   pvalid_reg;
    logic [WORD_W-1:0]  vrdata_reg;
    logic [WORD_W-1:0]  prdata_reg;
    logic               vrv_reg;
    logic               prv_reg;

    logic               v_rd_en, v_wr_en, p_rd_en, p_wr_en;
    logic [WADDR_W-1:0] v_rd_addr, v_wr_addr, p_rd_addr, p_wr_addr;
    logic [WORD_W-1:0]  v_wr_data, p_wr_data;

    logic [3:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   run_reg, run_next;
    logic [WADDR_W-1:0] vw_reg, vw_next;
    logic [CSEL_W-1:0]  chunk_reg, chunk_next;
    logic [IDX_W-1:0]   vstart_reg, vstart_next;
    logic [IDX_W-1:0]   vend_reg, vend_next;
    logic [WADDR_W-1:0] mark_reg, mark_next;
    logic [IDX_W-1:0]   vidx_reg, vidx_next;
    logic [CNT_W-1:0]   emit_reg, emit_next;
    logic [WADDR_W-1:0] pw_reg, pw_next;
    logic [WORD_W-1:0]  pword_reg, pword_next;
    logic [1:0]         wb_mode_reg, wb_mode_next;
    logic [ST_W-1:0]    fail_st_reg, fail_st_next;

    logic               out_valid_reg;
    logic [PAGE_W-1:0]  out_virt_reg, out_phys_reg;
    logic [ST_W-1:0]    out_status_reg;
    logic               out_last_reg;
    logic               out_free;
    logic               emit;
    logic [PAGE_W-1:0]  emit_virt, emit_phys;
    logic [ST_W-1:0]    emit_status;
    logic               emit_last;

    logic [WORD_W-1:0]  vword, pword_rd;
    logic [CHUNK_W-1:0] vchunk, pchunk;
    logic [IDX_W-1:0]   vbase, pbase;
    logic               v_in_pool, p_in_pool;
    logic               v_found;
    logic [IDX_W-1:0]   v_end;
    logic [CNT_W-1:0]   v_run;
    logic               p_found;
    logic [BSEL_W-1:0]  p_bit;
    logic [WORD_W-1:0]  mark_mask;
    logic [CNT_W-1:0]   emit_inc;

    // Bitmap memories; a row never written reads as all free.
    always_ff @(posedge aclk) begin
        if (v_wr_en) begin
            vmem[v_wr_addr] <= v_wr_data;
        end
        if (v_rd_en) begin
            vrdata_reg <= vmem[v_rd_addr];
        end
        if (p_wr_en) begin
            pmem[p_wr_addr] <= p_wr_data;
        end
        if (p_rd_en) begin
            prdata_reg <= pmem[p_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vvalid_reg <= '0;
            pvalid_reg <= '0;
            vrv_reg    <= 1'b0;
            prv_reg    <= 1'b0;
        end else begin
            if (v_wr_en) begin
                vvalid_reg[v_wr_addr] <= 1'b1;
            end
            if (p_wr_en) begin
                pvalid_reg[p_wr_addr] <= 1'b1;
            end
            if (v_rd_en) begin
                vrv_reg <= vvalid_reg[v_rd_addr];
            end
            if (p_rd_en) begin
                prv_reg <= pvalid_reg[p_rd_addr];
            end
        end
    end

    assign vword     = vrv_reg ? vrdata_reg : '0;
    assign pword_rd  = prv_reg ? prdata_reg : '0;
    assign vchunk    = vword[chunk_reg*CHUNK_W +: CHUNK_W];
    assign pchunk    = pword_reg[chunk_reg*CHUNK_W +: CHUNK_W];
    assign vbase     = {vw_reg, chunk_reg, BSEL_W'(0)};
    assign pbase     = {pw_reg, chunk_reg, BSEL_W'(0)};
    assign v_in_pool = LIMIT_W'(vbase) < cfg.limit;
    assign p_in_pool = LIMIT_W'(pbase) < cfg.limit;
    assign emit_inc  = emit_reg + CNT_W'(1);

    // Free-run count over one byte of the virtual bitmap.
    always_comb begin
        logic [CNT_W-1:0] r;
        logic             f;
        logic [IDX_W-1:0] e;
        r = run_reg;
        f = 1'b0;
        e = '0;
        for (int j = 0; j < CHUNK_W; j++) begin
            if (!f) begin
                if (vchunk[j]) begin
                    r = '0;
                end else begin
                    r = r + CNT_W'(1);
                end
                if (r == cnt_reg) begin
                    f = 1'b1;
                    e = vbase | IDX_W'(j);
                end
            end
        end
        v_run   = r;
        v_found = f;
        v_end   = e;
    end

    always_comb begin
        logic             f;
        logic [BSEL_W-1:0] b;
        f = 1'b0;
        b = '0;
        for (int j = 0; j < CHUNK_W; j++) begin
            if (!f && !pchunk[j]) begin
                f = 1'b1;
                b = BSEL_W'(j);
            end
        end
        p_found = f;
        p_bit   = b;
    end

    always_comb begin
        logic [IDX_W-1:0] idx;
        for (int b = 0; b < WORD_W; b++) begin
            idx = {mark_reg, (IDX_W - WADDR_W)'(b)};
            mark_mask[b] = (idx >= vstart_reg) && (idx <= vend_reg);
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        run_next     = run_reg;
        vw_next      = vw_reg;
        chunk_next   = chunk_reg;
        vstart_next  = vstart_reg;
        vend_next    = vend_reg;
        mark_next    = mark_reg;
        vidx_next    = vidx_reg;
        emit_next    = emit_reg;
        pw_next      = pw_reg;
        pword_next   = pword_reg;
        wb_mode_next = wb_mode_reg;
        fail_st_next = fail_st_reg;
        pop          = 1'b0;
        v_rd_en      = 1'b0;
        v_rd_addr    = '0;
        v_wr_en      = 1'b0;
        v_wr_addr    = mark_reg;
        v_wr_data    = vword | mark_mask;
        p_rd_en      = 1'b0;
        p_rd_addr    = '0;
        p_wr_en      = 1'b0;
        p_wr_addr    = pw_reg;
        p_wr_data    = pword_reg;
        emit         = 1'b0;
        emit_virt    = '0;
        emit_phys    = '0;
        emit_status  = ST_OK;
        emit_last    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (q_in.valid) begin
                    pop      = 1'b1;
                    cnt_next = q_in.req.count;
                    if (q_in.req.bad) begin
                        fail_st_next = ST_NO_VIRT;
                        state_next   = S_FAIL;
                    end else begin
                        run_next   = '0;
                        vw_next    = '0;
                        chunk_next = '0;
                        v_rd_en    = 1'b1;
                        state_next = S_VSCAN;
                    end
                end
            end
            S_VSCAN: begin
                if (!v_in_pool) begin
                    fail_st_next = ST_NO_VIRT;
                    state_next   = S_FAIL;
                end else if (v_found) begin
                    vstart_next = v_end + IDX_W'(1) - IDX_W'(cnt_reg);
                    vend_next   = v_end;
                    mark_next   = vstart_next[IDX_W-1 -: WADDR_W];
                    vidx_next   = vstart_next;
                    state_next  = S_VMRD;
                end else begin
                    run_next = v_run;
                    if (chunk_reg == LAST_CHUNK) begin
                        if (vw_reg == LAST_WORD) begin
                            fail_st_next = ST_NO_VIRT;
                            state_next   = S_FAIL;
                        end else begin
                            vw_next    = vw_reg + WADDR_W'(1);
                            chunk_next = '0;
                            v_rd_en    = 1'b1;
                            v_rd_addr  = vw_next;
                        end
                    end else begin
                        chunk_next = chunk_reg + CSEL_W'(1);
                    end
                end
            end
            S_VMRD: begin
                v_rd_en    = 1'b1;
                v_rd_addr  = mark_reg;
                state_next = S_VMWR;
            end
            S_VMWR: begin
                v_wr_en = 1'b1;
                if (mark_reg == vend_reg[IDX_W-1 -: WADDR_W]) begin
                    pw_next    = '0;
                    emit_next  = '0;
                    p_rd_en    = 1'b1;
                    state_next = S_PLOAD;
                end else begin
                    mark_next  = mark_reg + WADDR_W'(1);
                    state_next = S_VMRD;
                end
            end
            S_PLOAD: begin
                pword_next = pword_rd;
                chunk_next = '0;
                state_next = S_PSCAN;
            end
            S_PSCAN: begin
                if (!p_in_pool) begin
                    wb_mode_next = WB_FAIL;
                    state_next   = S_PWB;
                end else if (p_found) begin
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_virt   = cfg.virt_base + PAGE_W'(vidx_reg);
                        emit_phys   = cfg.phys_base + PAGE_W'(pbase | IDX_W'(p_bit));
                        emit_status = ST_OK;
                        emit_last   = (emit_inc == cnt_reg);
                        pword_next  = pword_reg | (WORD_W'(1) << {chunk_reg, p_bit});
                        emit_next   = emit_inc;
                        vidx_next   = vidx_reg + IDX_W'(1);
                        if (emit_inc == cnt_reg) begin
                            wb_mode_next = WB_DONE;
                            state_next   = S_PWB;
                        end
                    end
                end else if (chunk_reg == LAST_CHUNK) begin
                    wb_mode_next = WB_NEXT;
                    state_next   = S_PWB;
                end else begin
                    chunk_next = chunk_reg + CSEL_W'(1);
                end
            end
            S_PWB: begin
                p_wr_en = 1'b1;
                case (wb_mode_reg)
                    WB_DONE: state_next = S_IDLE;
                    WB_NEXT: begin
                        if (pw_reg == LAST_WORD) begin
                            fail_st_next = ST_NO_PHYS;
                            state_next   = S_FAIL;
                        end else begin
                            pw_next    = pw_reg + WADDR_W'(1);
                            p_rd_en    = 1'b1;
                            p_rd_addr  = pw_next;
                            state_next = S_PLOAD;
                        end
                    end
                    default: begin
                        fail_st_next = ST_NO_PHYS;
                        state_next   = S_FAIL;
                    end
                endcase
            end
            S_FAIL: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_status = fail_st_reg;
                    emit_last   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        run_reg     <= run_next;
        vw_reg      <= vw_next;
        chunk_reg   <= chunk_next;
        vstart_reg  <= vstart_next;
        vend_reg    <= vend_next;
        mark_reg    <= mark_next;
        vidx_reg    <= vidx_next;
        emit_reg    <= emit_next;
        pw_reg      <= pw_next;
        pword_reg   <= pword_next;
        wb_mode_reg <= wb_mode_next;
        fail_st_reg <= fail_st_next;
        if (emit) begin
            out_virt_reg   <= emit_virt;
            out_phys_reg   <= emit_phys;
            out_status_reg <= emit_status;
            out_last_reg   <= emit_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_virt   = out_virt_reg;
    assign out_phys   = out_phys_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

endmodule
